// ----- src/arp_spoof_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// ARP spoof monitor assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARP_SPOOF_MONITOR_MACROS_SVH
`define ARP_SPOOF_MONITOR_MACROS_SVH

// same-cycle implication
`define ASM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/asm_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP spoof monitor package
// Field widths, operation codes and the compare unit control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asm_pkg;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = 3;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int COUNT_W = 4;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic clear;
      logic step;
   } cmp_ctl_type;

endpackage

`default_nettype wire

// ----- src/asm_if.sv -----
// ----------------------------------------------------------------------------
// ARP spoof monitor channels
// Valid/ready interfaces for the operation channel and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface asm_req_if;
   logic                            valid;
   logic                            ready;
   logic [asm_pkg::OP_W-1:0]        op;
   logic [asm_pkg::SLOT_W-1:0]      entry_index;
   logic [asm_pkg::IP_W-1:0]        ip_addr;
   logic [asm_pkg::MAC_W-1:0]       mac_addr;
   logic [asm_pkg::IP_W-1:0]        sender_ip;

   modport source (output valid, op, entry_index, ip_addr, mac_addr, sender_ip,
                   input ready);
   modport sink   (input valid, op, entry_index, ip_addr, mac_addr, sender_ip,
                   output ready);
endinterface

interface asm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            alert;
   logic                            newly_recorded;
   logic                            alarm_on;
   logic signed [asm_pkg::COUNT_W-1:0] attacked_count;
   logic [asm_pkg::IP_W-1:0]        offender_ip;
   logic [asm_pkg::MAC_W-1:0]       offender_mac;

   modport source (output valid, alert, newly_recorded, alarm_on, attacked_count,
                   offender_ip, offender_mac, input ready);
   modport sink   (input valid, alert, newly_recorded, alarm_on, attacked_count,
                   offender_ip, offender_mac, output ready);
endinterface

`default_nettype wire

// ----- src/asm_match_unit.sv -----
// ----------------------------------------------------------------------------
// ARP spoof monitor match unit
// Shared 48-bit equality compare with a sticky hit flag over one scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asm_match_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  asm_pkg::cmp_ctl_type         ctl,
   input  wire  [asm_pkg::MAC_W-1:0]    oper_a,
   input  wire  [asm_pkg::MAC_W-1:0]    oper_b,
   output logic                         hit
);

   logic hit_ff;
   logic equal;

   assign equal = (oper_a == oper_b);
   assign hit   = hit_ff | (ctl.step & equal);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.clear) begin
         hit_ff <= 1'b0;
      end else if (ctl.step) begin
         hit_ff <= hit_ff | equal;
      end
   end

endmodule

`default_nettype wire

// ----- src/arp_spoof_monitor.sv -----
// ----------------------------------------------------------------------------
// ARP spoof monitor
// Trusted IP/MAC table, attacked-IP ring and latched alarm, scanned by one
// shared comparator under a small sequencer.
//
//   Channel  Dir  Handshake     Payload
//   req      in   valid/ready   op, entry_index, ip_addr, mac_addr, sender_ip
//   rsp      out  valid/ready   alert, newly_recorded, alarm_on, attacked_count,
//                               offender_ip, offender_mac
//
// Load, clear and unused op: the accepted item goes through S_DONE into the rsp register.
// Check: scans S_IP, then S_MAC, then S_RING, one table entry per cycle through
// the single 48-bit comparator, then S_DONE; the MAC scan is skipped on an IP
// miss and the ring scan on a trusted MAC.
// One item in flight; the next is taken once the result sits in the rsp register.
// A stalled rsp holds the finished item and the sequencer in its last state.
// Synchronous reset zeroes all tables, sets the ring pointer to one, drops alarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arp_spoof_monitor_macros.svh"

module arp_spoof_monitor #(
   parameter int TRUSTED_ENTRIES  = 5,
   parameter int ATTACKED_ENTRIES = 8
) (
   input  wire       clock,
   input  wire       reset,
   asm_req_if.sink   req,
   asm_rsp_if.source rsp
);

   localparam int MAX_ENTRIES = (TRUSTED_ENTRIES > ATTACKED_ENTRIES) ?
                                TRUSTED_ENTRIES : ATTACKED_ENTRIES;
   localparam int CNT_W = $clog2(MAX_ENTRIES);
   localparam int TI_W  = (TRUSTED_ENTRIES > 1) ? $clog2(TRUSTED_ENTRIES) : 1;
   localparam int PTR_W = $clog2(ATTACKED_ENTRIES);
   localparam int IP_W  = asm_pkg::IP_W;
   localparam int MAC_W = asm_pkg::MAC_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_IP,
      S_MAC,
      S_RING,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       ip_hit_ff;
   logic                       mac_hit_ff;
   logic                       ring_hit_ff;
   logic [PTR_W-1:0]           ptr_ff;
   logic                       alarm_ff;

   logic [asm_pkg::OP_W-1:0]   op_ff;
   logic [asm_pkg::SLOT_W-1:0] slot_ff;
   logic [IP_W-1:0]            ip_ff;
   logic [MAC_W-1:0]           mac_ff;
   logic [IP_W-1:0]            sip_ff;

   logic [IP_W-1:0]            trusted_ip_ff  [TRUSTED_ENTRIES];
   logic [MAC_W-1:0]           trusted_mac_ff [TRUSTED_ENTRIES];
   logic [IP_W-1:0]            attacked_ff    [ATTACKED_ENTRIES];

   logic                       rsp_valid_ff;
   logic                       rsp_alert_ff;
   logic                       rsp_rec_ff;
   logic                       rsp_alarm_ff;
   logic [asm_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [IP_W-1:0]            rsp_ip_ff;
   logic [MAC_W-1:0]           rsp_mac_ff;

   asm_pkg::cmp_ctl_type       cmp_ctl;
   logic [MAC_W-1:0]           oper_a;
   logic [MAC_W-1:0]           oper_b;
   logic                       hit;
   logic                       last;
   logic                       accept;
   logic                       out_free;
   logic                       alert;
   logic                       recorded;
   logic [PTR_W-1:0]           ptr_in;

   assign accept   = req.valid & req.ready;
   assign out_free = ~rsp_valid_ff | rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      oper_a = '0;
      oper_b = '0;
      last   = 1'b0;
      unique case (state_ff)
         S_IP: begin
            oper_a = MAC_W'(trusted_ip_ff[cnt_ff[TI_W-1:0]]);
            oper_b = MAC_W'(ip_ff);
            last   = (cnt_ff == CNT_W'(TRUSTED_ENTRIES - 1));
         end
         S_MAC: begin
            oper_a = trusted_mac_ff[cnt_ff[TI_W-1:0]];
            oper_b = mac_ff;
            last   = (cnt_ff == CNT_W'(TRUSTED_ENTRIES - 1));
         end
         S_RING: begin
            oper_a = MAC_W'(attacked_ff[cnt_ff[PTR_W-1:0]]);
            oper_b = MAC_W'(ip_ff);
            last   = (cnt_ff == CNT_W'(ATTACKED_ENTRIES - 1));
         end
         S_IDLE, S_DONE: begin
            last = 1'b0;
         end
         default: begin
            last = 1'b0;
         end
      endcase
   end

   assign cmp_ctl.step  = (state_ff == S_IP) | (state_ff == S_MAC) | (state_ff == S_RING);
   assign cmp_ctl.clear = (state_ff == S_IDLE) | (cmp_ctl.step & last);

   asm_match_unit u_match (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cmp_ctl),
      .oper_a (oper_a),
      .oper_b (oper_b),
      .hit    (hit)
   );

   assign alert    = (op_ff == asm_pkg::OP_CHECK) & ip_hit_ff & ~mac_hit_ff;
   assign recorded = alert & ~ring_hit_ff;
   assign ptr_in   = ~recorded ? ptr_ff :
                     (ptr_ff == PTR_W'(ATTACKED_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ip_hit_ff    <= 1'b0;
         mac_hit_ff   <= 1'b0;
         ring_hit_ff  <= 1'b0;
         ptr_ff       <= PTR_W'(1);
         alarm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TRUSTED_ENTRIES; i++) begin
            trusted_ip_ff[i]  <= '0;
            trusted_mac_ff[i] <= '0;
         end
         for (int i = 0; i < ATTACKED_ENTRIES; i++) begin
            attacked_ff[i] <= '0;
         end
      end else begin
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff       <= req.op;
                  slot_ff     <= req.entry_index;
                  ip_ff       <= req.ip_addr;
                  mac_ff      <= req.mac_addr;
                  sip_ff      <= req.sender_ip;
                  cnt_ff      <= '0;
                  ip_hit_ff   <= 1'b0;
                  mac_hit_ff  <= 1'b0;
                  ring_hit_ff <= 1'b0;
                  state_ff    <= (req.op == asm_pkg::OP_CHECK) ? S_IP : S_DONE;
               end
            end
            S_IP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (last) begin
                  ip_hit_ff <= hit;
                  cnt_ff    <= '0;
                  state_ff  <= hit ? S_MAC : S_DONE;
               end
            end
            S_MAC: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (last) begin
                  mac_hit_ff <= hit;
                  cnt_ff     <= '0;
                  state_ff   <= hit ? S_DONE : S_RING;
               end
            end
            S_RING: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (last) begin
                  ring_hit_ff <= hit;
                  cnt_ff      <= '0;
                  state_ff    <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  if (op_ff == asm_pkg::OP_LOAD) begin
                     for (int i = 0; i < TRUSTED_ENTRIES; i++) begin
                        if (32'(slot_ff) == i) begin
                           trusted_ip_ff[i]  <= ip_ff;
                           trusted_mac_ff[i] <= mac_ff;
                        end
                     end
                  end
                  if (op_ff == asm_pkg::OP_CLEAR) begin
                     for (int i = 0; i < ATTACKED_ENTRIES; i++) begin
                        attacked_ff[i] <= '0;
                     end
                  end
                  if (recorded) begin
                     attacked_ff[ptr_ff] <= ip_ff;
                  end
                  ptr_ff       <= ptr_in;
                  alarm_ff     <= alarm_ff | alert;
                  rsp_valid_ff <= 1'b1;
                  rsp_alert_ff <= alert;
                  rsp_rec_ff   <= recorded;
                  rsp_alarm_ff <= alarm_ff | alert;
                  rsp_count_ff <= asm_pkg::COUNT_W'(ptr_in) - 1'b1;
                  rsp_ip_ff    <= alert ? sip_ff : '0;
                  rsp_mac_ff   <= alert ? mac_ff : '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.alert          = rsp_alert_ff;
   assign rsp.newly_recorded = rsp_rec_ff;
   assign rsp.alarm_on       = rsp_alarm_ff;
   assign rsp.attacked_count = $signed(rsp_count_ff);
   assign rsp.offender_ip    = rsp_ip_ff;
   assign rsp.offender_mac   = rsp_mac_ff;

   `ASM_ASSERT_IMP(a_alert_sets_alarm, rsp.valid && rsp.alert, rsp.alarm_on, "alert without alarm")
   `ASM_ASSERT_IMP(a_record_needs_alert, rsp.valid && rsp.newly_recorded, rsp.alert, "record without alert")
   `ASM_ASSERT_NXT(a_alarm_sticks, alarm_ff, alarm_ff, "alarm released before reset")
   `ASM_ASSERT_NXT(a_busy_after_accept, accept, !req.ready, "ready while item in flight")

endmodule

`default_nettype wire
